// ===== design/sbtc_pkg.sv =====
// ----------------------------------------------------------------------------
// sbtc_pkg
// shared types and constants of the swept box tile collision block
// ----------------------------------------------------------------------------
package sbtc_pkg;

   localparam int COORD_W    = 20;  // U12.8 coordinate
   localparam int GAP_W      = 8;
   localparam int SPAN_SHIFT = 14;  // 64 pixel tile, 8 fraction bits
   localparam int MAP_IDX_W  = 6;   // 64 x 64 map
   localparam int MAP_LINES  = 64;
   localparam int LINE_W     = 7;   // line index incl. out-of-map lines
   localparam int SUM_W      = COORD_W + 1;

   localparam logic [GAP_W-1:0] GAP_RESET = 8'd3;

   localparam logic REQ_WRITE   = 1'b0;
   localparam logic REQ_RESOLVE = 1'b1;

   localparam logic [MAP_IDX_W-1:0] CLEAR_LAST = MAP_IDX_W'(MAP_LINES - 1);

   typedef enum logic [1:0] {
      SCAN_X_LEFT,
      SCAN_X_RIGHT,
      SCAN_Y_LEFT,
      SCAN_Y_RIGHT
   } scan_sel_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INIT,
      ST_READ,
      ST_CHECK,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic               req_type;
      logic [5:0]         tile_col;
      logic [5:0]         tile_row;
      logic               tile_solid;
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] start_w;
      logic [COORD_W-1:0] start_h;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
      logic [COORD_W-1:0] end_w;
      logic [COORD_W-1:0] end_h;
   } req_payload_type;

   typedef struct packed {
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
   } rsp_payload_type;

   typedef struct packed {
      scan_sel_type sel;
      logic         clear;
      logic         map_write;
      logic         load;
      logic         init;
      logic         step;
      logic         commit;
      logic         emit;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic need;
      logic hit;
      logic last;
   } dp_status_type;

endpackage

// ===== design/sbtc_datapath.sv =====
// ----------------------------------------------------------------------------
// sbtc_datapath
// tile maps, scan line counter, clamp arithmetic and result register
// ----------------------------------------------------------------------------
module sbtc_datapath import sbtc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req_data,
   input  logic            csr_wr_en,
   input  logic [GAP_W-1:0] csr_wr_data,
   input  dp_cmd_type      cmd,
   output dp_status_type   status,
   output rsp_payload_type rsp_data
);

   // same map kept twice: one word per column and one word per row
   logic [MAP_LINES-1:0] col_mem [MAP_LINES];
   logic [MAP_LINES-1:0] row_mem [MAP_LINES];

   req_payload_type      req_ff;
   logic [GAP_W-1:0]     gap_ff;
   logic [MAP_IDX_W-1:0] clr_addr_ff;
   logic [LINE_W-1:0]    p_ff, p_in;
   logic [LINE_W-1:0]    stop_ff, stop_in;
   logic [COORD_W-1:0]   pos_x_ff, pos_y_ff;
   logic [MAP_LINES-1:0] col_word_ff, row_word_ff;
   rsp_payload_type      rsp_ff;

   logic [SUM_W-1:0]   sx_far, sy_far, ex_far, ey_far;
   logic [LINE_W-1:0]  xlo, xhi, ylo, yhi, lo, hi;
   logic [MAP_LINES-1:0] mask, word;
   logic               is_x;
   logic               need;
   logic [COORD_W-1:0] s_sel, el_sel;
   logic [SUM_W:0]     v_left;
   logic signed [COORD_W+3:0] v_right;
   logic [COORD_W-1:0] clamp;

   assign sx_far = SUM_W'(req_ff.start_x) + SUM_W'(req_ff.start_w);
   assign sy_far = SUM_W'(req_ff.start_y) + SUM_W'(req_ff.start_h);
   assign ex_far = SUM_W'(req_ff.end_x) + SUM_W'(req_ff.end_w);
   assign ey_far = SUM_W'(req_ff.end_y) + SUM_W'(req_ff.end_h);

   assign xlo = LINE_W'(req_ff.start_x >> SPAN_SHIFT);
   assign xhi = LINE_W'(sx_far >> SPAN_SHIFT);
   assign ylo = LINE_W'(req_ff.start_y >> SPAN_SHIFT);
   assign yhi = LINE_W'(sy_far >> SPAN_SHIFT);

   assign is_x = (cmd.sel == SCAN_X_LEFT) || (cmd.sel == SCAN_X_RIGHT);

   // scan bounds and whether the scan applies
   always_comb begin
      unique case (cmd.sel)
         SCAN_X_LEFT: begin
            p_in    = LINE_W'(req_ff.start_x >> SPAN_SHIFT);
            stop_in = LINE_W'(req_ff.end_x >> SPAN_SHIFT);
            need    = req_ff.end_x < req_ff.start_x;
         end
         SCAN_X_RIGHT: begin
            p_in    = xhi;
            stop_in = LINE_W'(ex_far >> SPAN_SHIFT);
            need    = ex_far > sx_far;
         end
         SCAN_Y_LEFT: begin
            p_in    = LINE_W'(req_ff.start_y >> SPAN_SHIFT);
            stop_in = LINE_W'(req_ff.end_y >> SPAN_SHIFT);
            need    = req_ff.end_y < req_ff.start_y;
         end
         default: begin
            p_in    = yhi;
            stop_in = LINE_W'(ey_far >> SPAN_SHIFT);
            need    = ey_far > sy_far;
         end
      endcase
   end

   assign status.need = need;

   // cross range of the scanned line
   assign lo   = is_x ? ylo : xlo;
   assign hi   = is_x ? yhi : xhi;
   assign word = is_x ? col_word_ff : row_word_ff;

   always_comb begin
      for (int q = 0; q < MAP_LINES; q++) begin
         mask[q] = (LINE_W'(q) >= lo) && (LINE_W'(q) <= hi);
      end
   end

   // lines or cross lines beyond the map count as solid
   assign status.hit = p_ff[LINE_W-1] | hi[LINE_W-1] | (|(word & mask));
   assign status.last = p_ff == stop_ff;
   assign status.clear_last = clr_addr_ff == CLEAR_LAST;

   // clamp values
   assign s_sel  = is_x ? req_ff.start_x : req_ff.start_y;
   assign el_sel = is_x ? req_ff.end_w : req_ff.end_h;
   assign v_left = (SUM_W+1)'({p_ff + LINE_W'(1), {SPAN_SHIFT{1'b0}}}) + (SUM_W+1)'(gap_ff);
   assign v_right = $signed((COORD_W+4)'({p_ff, {SPAN_SHIFT{1'b0}}}))
                  - $signed((COORD_W+4)'(el_sel))
                  - $signed((COORD_W+4)'(gap_ff));

   always_comb begin
      if ((cmd.sel == SCAN_X_LEFT) || (cmd.sel == SCAN_Y_LEFT)) begin
         clamp = (v_left < (SUM_W+1)'(s_sel)) ? COORD_W'(v_left) : s_sel;
      end else begin
         clamp = (v_right > $signed((COORD_W+4)'(s_sel))) ? v_right[COORD_W-1:0] : s_sel;
      end
   end

   // map storage
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         col_mem[clr_addr_ff] <= '0;
         row_mem[clr_addr_ff] <= '0;
      end else if (cmd.map_write) begin
         col_mem[req_data.tile_col][req_data.tile_row] <= req_data.tile_solid;
         row_mem[req_data.tile_row][req_data.tile_col] <= req_data.tile_solid;
      end
      col_word_ff <= col_mem[p_ff[MAP_IDX_W-1:0]];
      row_word_ff <= row_mem[p_ff[MAP_IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff      <= GAP_RESET;
         clr_addr_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            gap_ff <= csr_wr_data;
         end
         if (cmd.clear) begin
            clr_addr_ff <= clr_addr_ff + MAP_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff   <= req_data;
         pos_x_ff <= req_data.end_x;
         pos_y_ff <= req_data.end_y;
      end
      if (cmd.init) begin
         p_ff    <= p_in;
         stop_ff <= stop_in;
      end else if (cmd.step) begin
         if ((cmd.sel == SCAN_X_LEFT) || (cmd.sel == SCAN_Y_LEFT)) begin
            p_ff <= p_ff - LINE_W'(1);
         end else begin
            p_ff <= p_ff + LINE_W'(1);
         end
      end
      if (cmd.commit) begin
         if (is_x) begin
            pos_x_ff <= clamp;
         end else begin
            pos_y_ff <= clamp;
         end
      end
      if (cmd.emit) begin
         rsp_ff.pos_x <= pos_x_ff;
         rsp_ff.pos_y <= pos_y_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== design/sbtc_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbtc_ctrl
// sequencer for map clear, tile writes and the four scans of a resolve
// ----------------------------------------------------------------------------
module sbtc_ctrl import sbtc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_is_resolve,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   ctrl_state_type state_ff, state_in;
   scan_sel_type   scan_ff, scan_in;
   logic           rsp_valid_ff;
   logic           scan_done;
   logic           can_emit;

   assign scan_done = (state_ff == ST_INIT && !status.need)
                   || (state_ff == ST_CHECK && (status.hit || status.last));
   assign can_emit  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (status.clear_last) state_in = ST_IDLE;
         ST_IDLE:  if (req_valid && req_is_resolve) state_in = ST_INIT;
         ST_INIT: begin
            if (status.need) state_in = ST_READ;
            else if (scan_ff == SCAN_Y_RIGHT) state_in = ST_EMIT;
         end
         ST_READ:  state_in = ST_CHECK;
         ST_CHECK: begin
            if (status.hit || status.last) begin
               state_in = (scan_ff == SCAN_Y_RIGHT) ? ST_EMIT : ST_INIT;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_EMIT:  if (can_emit) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd     = '0;
      cmd.sel = scan_ff;
      unique case (state_ff)
         ST_CLEAR: cmd.clear = 1'b1;
         ST_IDLE: begin
            cmd.load      = req_valid && req_is_resolve;
            cmd.map_write = req_valid && !req_is_resolve;
         end
         ST_INIT:  cmd.init = 1'b1;
         ST_READ:  cmd.init = 1'b0;
         ST_CHECK: begin
            cmd.commit = status.hit;
            cmd.step   = !status.hit && !status.last;
         end
         ST_EMIT:  cmd.emit = can_emit;
         default:  cmd.init = 1'b0;
      endcase
   end

   always_comb begin
      scan_in = scan_ff;
      if (cmd.load) begin
         scan_in = SCAN_X_LEFT;
      end else if (scan_done && scan_ff != SCAN_Y_RIGHT) begin
         scan_in = scan_sel_type'(scan_ff + 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         scan_ff      <= SCAN_X_LEFT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_EMIT))
      else $error("result overwritten while held");

   a_resolve_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_is_resolve) |=> (state_ff == ST_INIT && scan_ff == SCAN_X_LEFT))
      else $error("resolve did not start at first scan");

   a_scan_continue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && !status.hit && !status.last) |=> (state_ff == ST_READ))
      else $error("scan stopped early");

endmodule

// ===== design/swept_box_tile_collision_top.sv =====
// ----------------------------------------------------------------------------
// swept_box_tile_collision_top
// swept box against 64 x 64 tile solid map, x resolved before y
// ----------------------------------------------------------------------------
// after reset the block clears the map, one row and one column word per
// cycle, and stalls requests meanwhile; csr writes are taken at any time.
// a tile write beat is taken in idle and written to both maps. a resolve
// beat runs four scans (x left, x right, y left, y right); each scan that
// applies has a setup state and then, per probed tile line, a map word read
// followed by a hit check, a scan that does not apply ends in its setup
// state, and an emit state moves the answer to the output register; the
// line walk through the map memory sets the resolve time. the result sits
// in its own register, so the block returns to idle as soon as the answer
// is loaded there; a later resolve waits in its emit state until the held
// result beat is handed over on rsp_stall
// ----------------------------------------------------------------------------
module swept_box_tile_collision_top import sbtc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   // request beats
   input  logic             req_valid,
   output logic             req_stall,
   input  req_payload_type  req_data,
   // result beats
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_payload_type  rsp_data,
   // edge gap register
   input  logic             csr_wr_en,
   input  logic [GAP_W-1:0] csr_wr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer: clear pass, beat intake, scan order, result handoff
   sbtc_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_is_resolve (req_data.req_type == REQ_RESOLVE),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .cmd            (cmd),
      .status         (status)
   );

   // maps, line walk and clamp math
   sbtc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_data    (rsp_data)
   );

endmodule
